/* rtl/lzhc_pkg.sv */
// ----------------------------------------------------------------------------
// lzhc_pkg
// Shared types and constants of the lz77 hash chain table: item kinds,
// fixed field widths and the command bundle of the rolling hash unit.
// ----------------------------------------------------------------------------
package lzhc_pkg;

    // fixed widths of the item fields
    localparam int KIND_WIDTH     = 2;
    localparam int BYTE_WIDTH     = 8;
    localparam int POS_WIDTH      = 16;
    localparam int HASH_OUT_WIDTH = 15;

    // item kinds
    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_INSERT    = 2'd0,
        KIND_HASH_ONLY = 2'd1,
        KIND_NEXT      = 2'd2,
        KIND_SLIDE     = 2'd3
    } kind_t;

    // command to the rolling hash unit
    typedef struct packed {
        logic                  update;
        logic [BYTE_WIDTH-1:0] byte_value;
    } hash_cmd_t;

endpackage

/* rtl/lzhc_ram.sv */
// ----------------------------------------------------------------------------
// lzhc_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module lzhc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lzhc_hash.sv */
// ----------------------------------------------------------------------------
// lzhc_hash
// Rolling hash over the last few bytes: shift left and xor in the new byte,
// masked to the hash width. Gives the updated value ahead of the register so
// that the head table can be addressed in the same cycle.
// ----------------------------------------------------------------------------
module lzhc_hash #(
    parameter int HASH_WIDTH    = 15,
    parameter int MIN_MATCH_LEN = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lzhc_pkg::hash_cmd_t   cmd,
    output logic [HASH_WIDTH-1:0] hash_next,
    output logic [HASH_WIDTH-1:0] hash
);

    import lzhc_pkg::*;

    localparam int HSHIFT = (HASH_WIDTH + MIN_MATCH_LEN - 1) / MIN_MATCH_LEN;

    logic [HASH_WIDTH-1:0] hash_reg;
    logic [HASH_WIDTH-1:0] shifted;

    // shift and mix in the byte, upper bits fall off the top
    assign shifted   = hash_reg << HSHIFT;
    assign hash_next = shifted ^ HASH_WIDTH'(cmd.byte_value);

    // running hash register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
        end
        else if (cmd.update)
        begin
            hash_reg <= hash_next;
        end
    end

    assign hash = hash_reg;

endmodule

/* rtl/lz77_hash_chain_table.sv */
// ----------------------------------------------------------------------------
// lz77_hash_chain_table
// LZ77 match-finder hash chains with a head table and a prev table in RAM.
// ----------------------------------------------------------------------------
// An insert or next item issues the registered read of the head or prev RAM
// in the cycle it is accepted; the write-back and the load of the output
// register follow in the lookup state, which a hash_only item passes as well,
// and only then is a new item accepted. The output register lets the next
// item be accepted while a result waits; that item then holds in the lookup
// stage until the output register is free. A slide item walks both RAMs as a
// read-modify-write sweep, one entry per cycle, and holds the block until the
// sweep ends and its result is loaded. After reset a clearing pass writes zero
// to every entry of both RAMs before the first item is accepted.
// ----------------------------------------------------------------------------
module lz77_hash_chain_table #(
    parameter int HASH_WIDTH    = 15,
    parameter int WINDOW_SIZE   = 32768,
    parameter int MIN_MATCH_LEN = 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lzhc_pkg::KIND_WIDTH-1:0]      kind,
    input  logic [lzhc_pkg::BYTE_WIDTH-1:0]      byte_value,
    input  logic [lzhc_pkg::POS_WIDTH-1:0]       position,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lzhc_pkg::POS_WIDTH-1:0]       chain_position,
    output logic [lzhc_pkg::HASH_OUT_WIDTH-1:0]  hash_value
);

    import lzhc_pkg::*;

    localparam int HSIZE = 1 << HASH_WIDTH;
    localparam int HA_W  = HASH_WIDTH;
    localparam int PA_W  = $clog2(WINDOW_SIZE);
    localparam int MAXD  = (HSIZE > WINDOW_SIZE) ? HSIZE : WINDOW_SIZE;
    localparam int CNT_W = $clog2(MAXD) + 1;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_SWEEP  = 4'b1000
    } state_t;

    // window slide of one table entry
    function automatic logic [POS_WIDTH-1:0] slide_entry(input logic [POS_WIDTH-1:0] v);
        logic [POS_WIDTH-1:0] r;
        r = '0;
        if (v >= POS_WIDTH'(WINDOW_SIZE))
        begin
            r = v - POS_WIDTH'(WINDOW_SIZE);
        end
        return r;
    endfunction

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    kind_t                  kind_reg;
    logic [POS_WIDTH-1:0]   pos_reg;
    logic [HA_W-1:0]        hidx_reg;
    logic [PA_W-1:0]        pidx_reg;

    logic                   hsw_valid_reg;
    logic [HA_W-1:0]        hsw_addr_reg;
    logic                   psw_valid_reg;
    logic [PA_W-1:0]        psw_addr_reg;

    logic                   out_valid_reg;
    logic [POS_WIDTH-1:0]   chain_reg, chain_next;
    logic [HASH_OUT_WIDTH-1:0] hash_out_reg;
    logic                   out_load;

    logic                   in_ready;
    logic                   acc;
    kind_t                  in_kind;
    logic [PA_W-1:0]        prev_idx;

    hash_cmd_t              hash_cmd;
    logic [HA_W-1:0]        hash_next;
    logic [HA_W-1:0]        hash_cur;

    logic                   head_we, head_re;
    logic [HA_W-1:0]        head_waddr, head_raddr;
    logic [POS_WIDTH-1:0]   head_wdata, head_rdata;
    logic                   prev_we, prev_re;
    logic [PA_W-1:0]        prev_waddr, prev_raddr;
    logic [POS_WIDTH-1:0]   prev_wdata, prev_rdata;

    logic                   sweep_head_rd, sweep_prev_rd;
    logic                   out_free;

    // input handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_stall = !in_ready;
    assign acc      = in_valid && in_ready;
    assign in_kind  = kind_t'(kind);
    assign prev_idx = PA_W'(position & POS_WIDTH'(WINDOW_SIZE - 1));

    // rolling hash
    assign hash_cmd.update     = acc && (in_kind == KIND_INSERT || in_kind == KIND_HASH_ONLY);
    assign hash_cmd.byte_value = byte_value;

    lzhc_hash #(
        .HASH_WIDTH    (HASH_WIDTH),
        .MIN_MATCH_LEN (MIN_MATCH_LEN)
    ) u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (hash_cmd),
        .hash_next (hash_next),
        .hash      (hash_cur)
    );

    // sweep reads while the counter is inside each table
    assign sweep_head_rd = (state_reg == ST_SWEEP) && (cnt_reg < CNT_W'(HSIZE));
    assign sweep_prev_rd = (state_reg == ST_SWEEP) && (cnt_reg < CNT_W'(WINDOW_SIZE));

    // head table port select
    always_comb
    begin
        head_re    = 1'b0;
        head_raddr = hash_next;
        head_we    = 1'b0;
        head_waddr = hidx_reg;
        head_wdata = pos_reg;
        if (sweep_head_rd)
        begin
            head_re    = 1'b1;
            head_raddr = cnt_reg[HA_W-1:0];
        end
        else if (acc && in_kind == KIND_INSERT)
        begin
            head_re = 1'b1;
        end
        priority if (state_reg == ST_CLEAR)
        begin
            head_we    = cnt_reg < CNT_W'(HSIZE);
            head_waddr = cnt_reg[HA_W-1:0];
            head_wdata = '0;
        end
        else if (hsw_valid_reg)
        begin
            head_we    = 1'b1;
            head_waddr = hsw_addr_reg;
            head_wdata = slide_entry(head_rdata);
        end
        else if (state_reg == ST_LOOKUP && kind_reg == KIND_INSERT)
        begin
            head_we = 1'b1;
        end
    end

    // prev table port select
    always_comb
    begin
        prev_re    = 1'b0;
        prev_raddr = prev_idx;
        prev_we    = 1'b0;
        prev_waddr = pidx_reg;
        prev_wdata = head_rdata;
        if (sweep_prev_rd)
        begin
            prev_re    = 1'b1;
            prev_raddr = cnt_reg[PA_W-1:0];
        end
        else if (acc && in_kind == KIND_NEXT)
        begin
            prev_re = 1'b1;
        end
        priority if (state_reg == ST_CLEAR)
        begin
            prev_we    = cnt_reg < CNT_W'(WINDOW_SIZE);
            prev_waddr = cnt_reg[PA_W-1:0];
            prev_wdata = '0;
        end
        else if (psw_valid_reg)
        begin
            prev_we    = 1'b1;
            prev_waddr = psw_addr_reg;
            prev_wdata = slide_entry(prev_rdata);
        end
        else if (state_reg == ST_LOOKUP && kind_reg == KIND_INSERT)
        begin
            prev_we = 1'b1;
        end
    end

    lzhc_ram #(
        .WIDTH (POS_WIDTH),
        .DEPTH (HSIZE)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    lzhc_ram #(
        .WIDTH (POS_WIDTH),
        .DEPTH (WINDOW_SIZE)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (prev_re),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    // result of a lookup
    always_comb
    begin
        unique case (kind_reg)
            KIND_INSERT: chain_next = head_rdata;
            KIND_NEXT:   chain_next = prev_rdata;
            default:     chain_next = '0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAXD - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    cnt_next   = '0;
                    state_next = (in_kind == KIND_SLIDE) ? ST_SWEEP : ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // hold the read data until the output register is free
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (cnt_reg != CNT_W'(MAXD))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            hsw_valid_reg <= 1'b0;
            psw_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hsw_valid_reg <= sweep_head_rd;
            psw_valid_reg <= sweep_prev_rd;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and sweep payload registers
    always_ff @(posedge clk)
    begin
        hsw_addr_reg <= cnt_reg[HA_W-1:0];
        psw_addr_reg <= cnt_reg[PA_W-1:0];
        if (acc)
        begin
            kind_reg <= in_kind;
            pos_reg  <= position;
            hidx_reg <= hash_next;
            pidx_reg <= prev_idx;
        end
        if (out_load)
        begin
            chain_reg    <= (state_reg == ST_LOOKUP) ? chain_next : '0;
            hash_out_reg <= HASH_OUT_WIDTH'(POS_WIDTH'(hash_cur));
        end
    end

    assign out_valid      = out_valid_reg;
    assign chain_position = chain_reg;
    assign hash_value     = hash_out_reg;

`ifndef SYNTHESIS
    // an accepted item always moves into lookup or sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> (state_reg == ST_LOOKUP || state_reg == ST_SWEEP))
        else $error("accepted item did not start work");

    // the output register is only loaded when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while held");

    // a new result appears only at the end of a lookup or a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOOKUP || state_reg == ST_SWEEP))
        else $error("result without a finished item");

    // sweep write-back never collides with an insert write
    assert property (@(posedge clk) disable iff (!rst_n)
        (hsw_valid_reg || psw_valid_reg) |-> (state_reg == ST_SWEEP))
        else $error("sweep write outside the sweep");

    // the clearing pass runs only after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))
        else $error("clearing pass re-entered");
`endif

endmodule

/* tb/tb_lz77_hash_chain_table.sv */
// ----------------------------------------------------------------------------
// tb_lz77_hash_chain_table
// Self-checking bench for the lz77 hash chain table. Every accepted item is
// run through a local copy of the rolling hash, head table and prev table.
// Each returned item is compared with the oldest outstanding prediction.
// Directed items cover hash extremes, chain links, window aliasing and the
// slide. Random items are mostly byte streams with repeating content, so
// that chains grow deep, mixed with chain walks and unstructured noise.
// ----------------------------------------------------------------------------
module tb_lz77_hash_chain_table;
    import lzhc_pkg::*;

    localparam int HASH_W      = 15;
    localparam int WIN         = 32768;
    localparam int MATCH_LEN   = 3;
    localparam int HASH_SHIFT  = (HASH_W + MATCH_LEN - 1) / MATCH_LEN;
    localparam logic [POS_WIDTH-1:0] PREV_MASK = POS_WIDTH'(WIN - 1);
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [POS_WIDTH-1:0]      chain_position;
        logic [HASH_OUT_WIDTH-1:0] hash_value;
    } chain_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [KIND_WIDTH-1:0]     kind = '0;
    logic [BYTE_WIDTH-1:0]     byte_value = '0;
    logic [POS_WIDTH-1:0]      position = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [POS_WIDTH-1:0]      chain_position;
    logic [HASH_OUT_WIDTH-1:0] hash_value;

    // predicted state of the chain tables
    logic [HASH_W-1:0]    running_hash = '0;
    logic [POS_WIDTH-1:0] head_mem [0:(1 << HASH_W)-1];
    logic [POS_WIDTH-1:0] prev_mem [0:WIN-1];

    chain_result_t expected_results [$];
    chain_result_t oldest_result;

    int send_idle_pct = 37;
    int recv_idle_pct = 37;
    int hold_request  = 0;
    int hold_left     = 0;
    int items_accepted = 0;
    int stream_pos    = 0;
    int slides_left   = 3;
    int error_count   = 0;
    int cycle_count   = 0;

    lz77_hash_chain_table #(
        .HASH_WIDTH    (HASH_W),
        .WINDOW_SIZE   (WIN),
        .MIN_MATCH_LEN (MATCH_LEN)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .byte_value     (byte_value),
        .position       (position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .chain_position (chain_position),
        .hash_value     (hash_value)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // clear the predicted tables as the reset clearing pass does
    initial
    begin
        for (int i = 0; i < (1 << HASH_W); i++)
            head_mem[i] = '0;
        for (int i = 0; i < WIN; i++)
            prev_mem[i] = '0;
    end

    // apply one item to the predicted tables and give its result
    function automatic void advance_chain_tables(input kind_t k,
                                                 input logic [BYTE_WIDTH-1:0] b,
                                                 input logic [POS_WIDTH-1:0] p,
                                                 output chain_result_t r);
        logic [POS_WIDTH-1:0] link;
        link = '0;
        case (k)
            KIND_INSERT:
            begin
                running_hash = (running_hash << HASH_SHIFT) ^ HASH_W'(b);
                link = head_mem[running_hash];
                prev_mem[p & PREV_MASK] = link;
                head_mem[running_hash] = p;
            end
            KIND_HASH_ONLY:
                running_hash = (running_hash << HASH_SHIFT) ^ HASH_W'(b);
            KIND_NEXT:
                link = prev_mem[p & PREV_MASK];
            default:
            begin
                // entries inside the old window move down, older ones drop out
                for (int i = 0; i < (1 << HASH_W); i++)
                    head_mem[i] = (head_mem[i] >= WIN) ?
                                  POS_WIDTH'(head_mem[i] - WIN) : '0;
                for (int i = 0; i < WIN; i++)
                    prev_mem[i] = (prev_mem[i] >= WIN) ?
                                  POS_WIDTH'(prev_mem[i] - WIN) : '0;
            end
        endcase
        r.chain_position = link;
        r.hash_value     = HASH_OUT_WIDTH'(running_hash);
    endfunction

    // receiver: random stalls plus requested long hold-offs
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                error_count = error_count + 1;
                if (error_count <= REPORT_MAX)
                    $display("unexpected item: chain_position %h hash_value %h",
                             chain_position, hash_value);
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (chain_position !== oldest_result.chain_position ||
                    hash_value !== oldest_result.hash_value)
                begin
                    error_count = error_count + 1;
                    if (error_count <= REPORT_MAX)
                        $display("mismatch: chain_position exp %h got %h, hash_value exp %h got %h",
                                 oldest_result.chain_position, chain_position,
                                 oldest_result.hash_value, hash_value);
                end
            end
        end
    end

    // offer one item, wait for acceptance and record its prediction
    task automatic send_item(input kind_t k, input logic [BYTE_WIDTH-1:0] b,
                             input logic [POS_WIDTH-1:0] p,
                             output logic [POS_WIDTH-1:0] link_out);
        chain_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        byte_value <= b;
        position   <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_chain_tables(k, b, p, r);
        expected_results.push_back(r);
        link_out = r.chain_position;
        items_accepted = items_accepted + 1;
    endtask

    // stop offering and let every outstanding item come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // saturated and empty hash, extreme positions
    task automatic test_hash_extremes();
        logic [POS_WIDTH-1:0] link;
        send_item(KIND_HASH_ONLY, 8'hFF, 16'h0000, link);
        send_item(KIND_HASH_ONLY, 8'hFF, 16'hFFFF, link);
        send_item(KIND_HASH_ONLY, 8'hFF, 16'h0000, link);
        send_item(KIND_INSERT, 8'hFF, 16'hFFFF, link);
        send_item(KIND_HASH_ONLY, 8'h00, 16'hFFFF, link);
        send_item(KIND_INSERT, 8'h00, 16'h0000, link);
    endtask

    // three inserts on one hash build a chain, then walk it to its end
    task automatic test_chain_links();
        logic [POS_WIDTH-1:0] link;
        send_item(KIND_HASH_ONLY, 8'h41, 16'h0000, link);
        send_item(KIND_HASH_ONLY, 8'h41, 16'h0000, link);
        send_item(KIND_INSERT, 8'h41, 16'd100, link);
        send_item(KIND_INSERT, 8'h41, 16'd101, link);
        send_item(KIND_INSERT, 8'h41, 16'd102, link);
        send_item(KIND_NEXT, 8'h00, 16'd102, link);
        send_item(KIND_NEXT, 8'hFF, 16'd101, link);
        send_item(KIND_NEXT, 8'h00, 16'd100, link);
    endtask

    // positions a window apart share one prev entry; unwritten entry reads 0
    task automatic test_window_alias();
        logic [POS_WIDTH-1:0] link;
        send_item(KIND_INSERT, 8'h41, 16'h8064, link);
        send_item(KIND_NEXT, 8'h00, 16'h0064, link);
        send_item(KIND_NEXT, 8'h00, 16'h1234, link);
    endtask

    // slide after the block has gone quiet, then look at moved entries
    task automatic test_slide();
        logic [POS_WIDTH-1:0] link;
        wait_for_results();
        send_item(KIND_SLIDE, 8'hA5, 16'h5A5A, link);
        send_item(KIND_NEXT, 8'h00, 16'h0064, link);
        send_item(KIND_INSERT, 8'h41, 16'd200, link);
        send_item(KIND_HASH_ONLY, 8'hFF, 16'h0000, link);
        send_item(KIND_HASH_ONLY, 8'hFF, 16'h0000, link);
        send_item(KIND_HASH_ONLY, 8'hFF, 16'h0000, link);
        send_item(KIND_INSERT, 8'hFF, 16'h00F0, link);
    endtask

    // byte streams with small alphabets, chain walks, window slides, noise
    task automatic run_streams(input int n_items);
        int start_count;
        int alphabet;
        int burst_len;
        int walk_steps;
        kind_t k;
        logic [BYTE_WIDTH-1:0] base_byte;
        logic [BYTE_WIDTH-1:0] b;
        logic [POS_WIDTH-1:0] link;
        start_count = items_accepted;
        while (items_accepted - start_count < n_items)
        begin
            if ($urandom_range(99) < 15)
            begin
                // unstructured item, rarely a slide
                k = kind_t'($urandom_range(3));
                if (k == KIND_SLIDE && (slides_left == 0 || $urandom_range(19) != 0))
                    k = KIND_NEXT;
                if (k == KIND_SLIDE)
                    slides_left = slides_left - 1;
                send_item(k, BYTE_WIDTH'($urandom), POS_WIDTH'($urandom), link);
            end
            else
            begin
                alphabet  = $urandom_range(1, 4);
                base_byte = BYTE_WIDTH'($urandom);
                burst_len = $urandom_range(3, 24);
                for (int j = 0; j < burst_len; j++)
                begin
                    b = base_byte + BYTE_WIDTH'($urandom_range(alphabet - 1));
                    // window full: slide it down, or restart low once slides run out
                    if (stream_pos > 65535)
                    begin
                        if (slides_left > 0)
                        begin
                            send_item(KIND_SLIDE, BYTE_WIDTH'($urandom),
                                      POS_WIDTH'($urandom), link);
                            slides_left = slides_left - 1;
                            stream_pos  = stream_pos - WIN;
                        end
                        else
                            stream_pos = $urandom_range(1, 4095);
                    end
                    if ($urandom_range(9) < 2)
                        send_item(KIND_HASH_ONLY, b, POS_WIDTH'(stream_pos), link);
                    else
                    begin
                        send_item(KIND_INSERT, b, POS_WIDTH'(stream_pos), link);
                        if (link != 0 && $urandom_range(3) == 0)
                        begin
                            walk_steps = $urandom_range(1, 6);
                            while (link != 0 && walk_steps > 0)
                            begin
                                send_item(KIND_NEXT, BYTE_WIDTH'($urandom), link, link);
                                walk_steps = walk_steps - 1;
                            end
                        end
                    end
                    stream_pos = stream_pos + 1;
                end
                if ($urandom_range(9) < 3)
                    stream_pos = stream_pos + $urandom_range(100, 3000);
            end
        end
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_request  = 400;
        run_streams(40);
        send_idle_pct = 37;
    endtask

    // a stretch with no idling on either side
    task automatic test_no_gaps();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_streams(250);
        send_idle_pct = 37;
        recv_idle_pct = 37;
    endtask

    // test sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        stream_pos = $urandom_range(1, 50000);
        test_hash_extremes();
        test_chain_links();
        test_window_alias();
        test_slide();
        run_streams(400);
        test_backpressure();
        test_no_gaps();
        run_streams(510);
        wait_for_results();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
